// ===== rtl/scmh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package scmh_pkg;

  // Field widths of the sample and result words.
  localparam int AXIS_W = 16;
  localparam int SQ_W   = 31;
  localparam int MAG_W  = 32;
  localparam int THR_W  = 35;
  localparam int CNT_W  = 32;

  // Threshold values after reset.
  localparam logic [THR_W-1:0] UPPER_RESET = 35'd3240000000;
  localparam logic [THR_W-1:0] LOWER_RESET = 35'd2890000000;

  // Configuration register indexes.
  typedef enum logic {
    REG_UPPER = 1'b0,
    REG_LOWER = 1'b1
  } cfg_idx_t;

  // Command codes carried in the sample word.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Per-word control that travels down the pipeline.
  typedef struct packed {
    logic clear;
    logic filling;
    logic decide;
    logic full;
  } scmh_ctl_t;

  // One result word.
  typedef struct packed {
    logic [CNT_W-1:0] step_count;
    logic             high_phase;
    logic             window_full;
  } scmh_res_t;

endpackage

`default_nettype wire

// ===== rtl/scmh_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sample channel: command plus three signed axes.
interface scmh_sample_if;
  import scmh_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic signed [AXIS_W-1:0] accel_x;
  logic signed [AXIS_W-1:0] accel_y;
  logic signed [AXIS_W-1:0] accel_z;

  modport source (output valid, cmd, accel_x, accel_y, accel_z, input ready);
  modport sink (input valid, cmd, accel_x, accel_y, accel_z, output ready);
endinterface

// Result channel: step count and detector status.
interface scmh_result_if;
  import scmh_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] step_count;
  logic             high_phase;
  logic             window_full;

  modport source (output valid, step_count, high_phase, window_full, input ready);
  modport sink (input valid, step_count, high_phase, window_full, output ready);
endinterface

`default_nettype wire

// ===== rtl/scmh_square_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scmh_square_lane (
  input  wire logic                             clk,
  input  wire logic                             adv,
  input  wire logic signed [scmh_pkg::AXIS_W-1:0] axis,
  output logic        [scmh_pkg::SQ_W-1:0]      sq
);
  import scmh_pkg::*;

  logic signed [2*AXIS_W-1:0] prod;

  // The square of a 16-bit value is never negative and fits in 31 bits.
  assign prod = (2*AXIS_W)'(axis) * (2*AXIS_W)'(axis);

  always_ff @(posedge clk) begin
    if (adv) begin
      sq <= prod[SQ_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/scmh_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scmh_merge (
  input  wire logic                        clk,
  input  wire logic                        adv,
  input  wire logic [scmh_pkg::SQ_W-1:0]   sq_x,
  input  wire logic [scmh_pkg::SQ_W-1:0]   sq_y,
  input  wire logic [scmh_pkg::SQ_W-1:0]   sq_z,
  output logic      [scmh_pkg::MAG_W-1:0]  mag
);
  import scmh_pkg::*;

  // Three squares of at most 2^30 each sum below 2^32.
  always_ff @(posedge clk) begin
    if (adv) begin
      mag <= MAG_W'(sq_x) + MAG_W'(sq_y) + MAG_W'(sq_z);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/scmh_window.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scmh_window #(
  parameter int WINDOW = 10
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        adv,
  input  wire logic [$clog2(WINDOW)-1:0]                   rd_pos,
  input  wire logic                                        wr_en,
  input  wire logic [$clog2(WINDOW)-1:0]                   wr_pos,
  input  wire logic [scmh_pkg::MAG_W-1:0]                  mag,
  input  wire logic                                        filling,
  output logic      [scmh_pkg::MAG_W+$clog2(WINDOW)-1:0]   sum
);
  import scmh_pkg::*;

  localparam int SUM_W = MAG_W + $clog2(WINDOW);

  logic [MAG_W-1:0] ring [WINDOW];
  logic [MAG_W-1:0] old_q;
  logic [SUM_W-1:0] sum_next;

  // Ring of magnitudes; the entry about to be replaced is read one stage ahead.
  always_ff @(posedge clk) begin
    if (adv) begin
      old_q <= ring[rd_pos];
    end
    if (wr_en) begin
      ring[wr_pos] <= mag;
    end
  end

  // Running sum: add the new magnitude, drop the one it replaces once full.
  always_comb begin
    sum_next = sum + SUM_W'(mag) - (filling ? '0 : SUM_W'(old_q));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (wr_en) begin
      sum <= sum_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/step_counter_magnitude_hysteresis.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Step detector on accelerometer magnitude with a moving-sum hysteresis.
// Channels: "samples" carries one word per sample (cmd, accel_x/y/z);
// cmd = 1 clears the step count and leaves everything else as it is.
// "results" returns exactly one word per sample word, in order: the step
// count, the high-phase flag and the window-full flag after that word.
// Thresholds are written through cfg_wen/cfg_idx/cfg_wdata while idle.
// Throughput is one word per cycle while the skid register is free; a
// word passes the squarer registers, the merge register, the running-sum
// register and the output register. Three squarer lanes and a merge
// adder form the magnitude, and a running sum over a ring of WINDOW
// magnitudes feeds the threshold compare.
// Reset clears the step count, phase, fill count, ring position and
// running sum, and loads the default thresholds; the ring needs no clear.
// When the receiver stalls, one more result parks in a skid register;
// samples.ready falls only while that register is occupied, and then
// the whole pipeline holds until the output is taken.
module step_counter_magnitude_hysteresis #(
  parameter int WINDOW = 10
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wen,
  input  wire scmh_pkg::cfg_idx_t           cfg_idx,
  input  wire logic [scmh_pkg::THR_W-1:0]   cfg_wdata,
  scmh_sample_if.sink                       samples,
  scmh_result_if.source                     results
);
  import scmh_pkg::*;

  localparam int POS_W  = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = MAG_W + $clog2(WINDOW);
  localparam int CMP_W  = (SUM_W > THR_W) ? SUM_W : THR_W;

  localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(WINDOW - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WINDOW - 1);

  logic [THR_W-1:0]  upper;
  logic [THR_W-1:0]  lower;
  logic [POS_W-1:0]  wr_pos;
  logic [FILL_W-1:0] fill_count;

  logic              adv;
  logic              accept;
  logic              is_sample;
  scmh_ctl_t         ctl_in;
  logic              v1, v2, v3;
  scmh_ctl_t         ctl1, ctl2, ctl3;
  logic [POS_W-1:0]  pos1, pos2;

  logic [SQ_W-1:0]   sq_x, sq_y, sq_z;
  logic [MAG_W-1:0]  mag;
  logic [SUM_W-1:0]  sum;
  logic              wr_en;

  logic [CNT_W-1:0]  steps, steps_next;
  logic              phase, phase_next;
  logic [CMP_W-1:0]  sum_ext, upper_ext, lower_ext;
  logic              res_v;
  scmh_res_t         res_word;

  scmh_res_t         out_q, skid_q;
  logic              out_valid, skid_valid;
  logic              pop;

  // Threshold registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      upper <= UPPER_RESET;
      lower <= LOWER_RESET;
    end else if (cfg_wen) begin
      case (cfg_idx)
        REG_UPPER: upper <= cfg_wdata;
        REG_LOWER: lower <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: the pipeline moves as one while the skid register is free.
  assign adv           = !skid_valid;
  assign samples.ready = adv;
  assign accept        = samples.valid && adv;
  assign is_sample     = accept && (samples.cmd == CMD_SAMPLE);

  // Control for the incoming word, taken from the ring state before it.
  always_comb begin
    ctl_in.clear   = (samples.cmd == CMD_CLEAR);
    ctl_in.filling = (fill_count < FILL_FULL);
    ctl_in.decide  = !ctl_in.clear && (fill_count == FILL_FULL);
    ctl_in.full    = (fill_count == FILL_FULL) ||
                     (!ctl_in.clear && (fill_count == FILL_LAST));
  end

  // Ring position advances on every accepted sample; the fill count until it reaches WINDOW.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos     <= '0;
      fill_count <= '0;
    end else if (is_sample) begin
      wr_pos <= (wr_pos == POS_LAST) ? '0 : wr_pos + 1'b1;
      if (fill_count < FILL_FULL) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= samples.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Pipeline control payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      ctl1 <= ctl_in;
      pos1 <= wr_pos;
      ctl2 <= ctl1;
      pos2 <= pos1;
      ctl3 <= ctl2;
    end
  end

  // Squarer lanes, one per axis.
  scmh_square_lane u_lane_x (.clk(clk), .adv(adv), .axis(samples.accel_x), .sq(sq_x));
  scmh_square_lane u_lane_y (.clk(clk), .adv(adv), .axis(samples.accel_y), .sq(sq_y));
  scmh_square_lane u_lane_z (.clk(clk), .adv(adv), .axis(samples.accel_z), .sq(sq_z));

  // Merge the lanes into the magnitude.
  scmh_merge u_merge (
    .clk  (clk),
    .adv  (adv),
    .sq_x (sq_x),
    .sq_y (sq_y),
    .sq_z (sq_z),
    .mag  (mag)
  );

  // Ring and running sum.
  assign wr_en = adv && v2 && !ctl2.clear;

  scmh_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .rd_pos  (pos1),
    .wr_en   (wr_en),
    .wr_pos  (pos2),
    .mag     (mag),
    .filling (ctl2.filling),
    .sum     (sum)
  );

  // Hysteresis decision on the window sum.
  assign sum_ext   = CMP_W'(sum);
  assign upper_ext = CMP_W'(upper);
  assign lower_ext = CMP_W'(lower);

  always_comb begin
    steps_next = steps;
    phase_next = phase;
    if (ctl3.clear) begin
      steps_next = '0;
    end else if (ctl3.decide) begin
      if ((sum_ext > upper_ext) && !phase) begin
        steps_next = steps + 1'b1;
        phase_next = 1'b1;
      end else if ((sum_ext < lower_ext) && phase) begin
        phase_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      phase <= 1'b0;
    end else if (res_v) begin
      steps <= steps_next;
      phase <= phase_next;
    end
  end

  assign res_v = adv && v3;

  always_comb begin
    res_word.step_count  = steps_next;
    res_word.high_phase  = phase_next;
    res_word.window_full = ctl3.full;
  end

  // Output register with a one-word skid register behind it.
  assign pop = out_valid && results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_v;
      end
    end else if (res_v) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid) begin
      out_q <= skid_valid ? skid_q : res_word;
    end else if (res_v) begin
      skid_q <= res_word;
    end
  end

  assign results.valid       = out_valid;
  assign results.step_count  = out_q.step_count;
  assign results.high_phase  = out_q.high_phase;
  assign results.window_full = out_q.window_full;

endmodule

`default_nettype wire

// ===== rtl/scmh_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scmh_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [scmh_pkg::CNT_W-1:0]  step_count,
  input wire logic                        high_phase,
  input wire logic                        window_full
);
  import scmh_pkg::*;

  logic             out_acc;
  logic             have_last;
  logic [CNT_W-1:0] last_count;
  logic             last_phase;
  logic             last_full;

  assign out_acc = out_valid && out_ready;

  // Remember the previous delivered word.
  always_ff @(posedge clk) begin
    if (rst) begin
      have_last  <= 1'b0;
      last_count <= '0;
      last_phase <= 1'b0;
      last_full  <= 1'b0;
    end else if (out_acc) begin
      have_last  <= 1'b1;
      last_count <= step_count;
      last_phase <= high_phase;
      last_full  <= window_full;
    end
  end

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word withdrawn while stalled");

  // The count holds, rises by one, or is cleared between delivered words.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    out_acc && have_last |->
      (step_count == '0) || (step_count == last_count) ||
      (step_count == last_count + 1'b1))
    else $error("step count jumped");

  // Entering the high phase counts exactly one step.
  a_rise_counts: assert property (@(posedge clk) disable iff (rst)
    out_acc && have_last && !last_phase && high_phase |->
      step_count == last_count + 1'b1)
    else $error("high phase entered without a counted step");

  // Once full, the window stays full.
  a_full_sticks: assert property (@(posedge clk) disable iff (rst)
    out_acc && have_last && last_full |-> window_full)
    else $error("window full flag dropped");

  // Input back-pressure only while a result word is pending.
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

endmodule

bind step_counter_magnitude_hysteresis scmh_checker u_scmh_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (samples.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .step_count  (results.step_count),
  .high_phase  (results.high_phase),
  .window_full (results.window_full)
);

`default_nettype wire

// ===== bench/step_count_checker.sv =====
`timescale 1ns / 1ps

// Watches the sample and result channels and the threshold port, predicts
// the detector status for every accepted sample word and compares it with
// the result words in order.
module step_count_checker #(
  parameter int WINDOW = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wen,
  input  scmh_pkg::cfg_idx_t         cfg_idx,
  input  logic [scmh_pkg::THR_W-1:0] cfg_wdata,
  scmh_sample_if                     samples,
  scmh_result_if                     results,
  output int                         fail_count,
  output int                         pending,
  output int                         rises
);
  import scmh_pkg::*;

  // Shadow of the detector state and thresholds.
  logic [MAG_W-1:0] mag_ring [WINDOW];
  int               ring_pos;
  int               ring_fill;
  logic             in_stride;
  logic [CNT_W-1:0] step_total;
  logic [THR_W-1:0] upper_thr;
  logic [THR_W-1:0] lower_thr;

  // Status words still owed by the block, oldest first.
  scmh_res_t expected_status[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    rises      = 0;
  end

  // Squared magnitude of one sample; three squares of 16-bit values always fit.
  function automatic logic [MAG_W-1:0] squared_mag(logic signed [AXIS_W-1:0] x,
                                                   logic signed [AXIS_W-1:0] y,
                                                   logic signed [AXIS_W-1:0] z);
    longint sx;
    longint sy;
    longint sz;
    sx = x;
    sy = y;
    sz = z;
    return MAG_W'(sx * sx + sy * sy + sz * sz);
  endfunction

  // Advances the shadow state by one sample word and returns the status after it.
  function automatic scmh_res_t predict_status(logic c, logic signed [AXIS_W-1:0] x,
                                               logic signed [AXIS_W-1:0] y,
                                               logic signed [AXIS_W-1:0] z);
    scmh_res_t        st;
    longint unsigned  win_sum;
    if (c == CMD_CLEAR) begin
      step_total = '0;
    end else begin
      mag_ring[ring_pos] = squared_mag(x, y, z);
      ring_pos = (ring_pos == WINDOW - 1) ? 0 : ring_pos + 1;
      if (ring_fill < WINDOW) begin
        // Still filling: the word that completes the ring decides nothing.
        ring_fill++;
      end else begin
        win_sum = 0;
        for (int i = 0; i < WINDOW; i++) win_sum += mag_ring[i];
        if (win_sum > upper_thr && !in_stride) begin
          step_total = step_total + 1'b1;
          in_stride  = 1'b1;
          rises++;
        end else if (win_sum < lower_thr && in_stride) begin
          in_stride = 1'b0;
        end
      end
    end
    st.step_count  = step_total;
    st.high_phase  = in_stride;
    st.window_full = (ring_fill >= WINDOW);
    return st;
  endfunction

  always @(posedge clk) begin
    scmh_res_t want;
    if (rst) begin
      ring_pos   = 0;
      ring_fill  = 0;
      in_stride  = 1'b0;
      step_total = '0;
      upper_thr  = UPPER_RESET;
      lower_thr  = LOWER_RESET;
      expected_status.delete();
    end else begin
      // Compare an accepted result word with the oldest prediction.
      if (results.valid && results.ready) begin
        if (expected_status.size() == 0) begin
          $error("result word with no prediction waiting: step_count %0d",
                 results.step_count);
          fail_count++;
        end else begin
          want = expected_status.pop_front();
          if (results.step_count !== want.step_count) begin
            $error("step_count: expected %0d, actual %0d", want.step_count,
                   results.step_count);
            fail_count++;
          end
          if (results.high_phase !== want.high_phase) begin
            $error("high_phase: expected %0b, actual %0b", want.high_phase,
                   results.high_phase);
            fail_count++;
          end
          if (results.window_full !== want.window_full) begin
            $error("window_full: expected %0b, actual %0b", want.window_full,
                   results.window_full);
            fail_count++;
          end
        end
      end

      // Threshold writes take effect for words accepted at this edge and after.
      if (cfg_wen) begin
        case (cfg_idx)
          REG_UPPER: upper_thr = cfg_wdata;
          REG_LOWER: lower_thr = cfg_wdata;
          default: ;
        endcase
      end

      if (samples.valid && samples.ready) begin
        expected_status.push_back(predict_status(samples.cmd, samples.accel_x,
                                                 samples.accel_y, samples.accel_z));
      end
    end
    pending = expected_status.size();
  end

endmodule

// ===== bench/step_counter_magnitude_hysteresis_test.sv =====
`timescale 1ns / 1ps

module step_counter_magnitude_hysteresis_test;
  import scmh_pkg::*;

  localparam int WINDOW            = 10;
  localparam int WORDS_PER_SETTING = 200;
  localparam int CALM_FROM         = 1275;
  localparam int CYCLE_LIMIT       = 200_000;

  localparam logic signed [AXIS_W-1:0] AX_MIN = 16'sh8000;
  localparam logic signed [AXIS_W-1:0] AX_MAX = 16'sh7FFF;
  localparam logic [THR_W-1:0]         THR_MAX = '1;

  logic             clk;
  logic             rst;
  logic             cfg_wen;
  cfg_idx_t         cfg_idx;
  logic [THR_W-1:0] cfg_wdata;

  scmh_sample_if samples ();
  scmh_result_if results ();

  int  fail_count;
  int  pending;
  int  rises;
  int  words_sent = 0;
  int  clears_sent = 0;
  int  settings_done = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  calm = 1'b0;

  step_counter_magnitude_hysteresis #(
    .WINDOW(WINDOW)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .samples  (samples),
    .results  (results)
  );

  step_count_checker #(
    .WINDOW(WINDOW)
  ) checker_i (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .samples   (samples),
    .results   (results),
    .fail_count(fail_count),
    .pending   (pending),
    .rises     (rises)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: stalls in short random bursts, never in the calm tail.
  always @(negedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      results.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 3);
      results.ready <= 1'b0;
    end else begin
      results.ready <= 1'b1;
    end
  end

  // Offers one sample word and returns at the edge that accepts it.
  task automatic send_word(logic c, logic signed [AXIS_W-1:0] x,
                           logic signed [AXIS_W-1:0] y, logic signed [AXIS_W-1:0] z);
    int gap;
    gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    samples.valid   <= 1'b1;
    samples.cmd     <= c;
    samples.accel_x <= x;
    samples.accel_y <= y;
    samples.accel_z <= z;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    words_sent++;
    if (c == CMD_CLEAR) clears_sent++;
    calm = (words_sent >= CALM_FROM);
  endtask

  // Holds the sender until every predicted word has come back.
  task automatic wait_drained();
    @(negedge clk);
    samples.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [THR_W-1:0] val);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  function automatic logic signed [AXIS_W-1:0] axis_within(int amp);
    return AXIS_W'($urandom_range(0, 2 * amp) - amp);
  endfunction

  // Walking-like stimulus: alternating loud and quiet bursts move the window
  // sum across the thresholds, with some full-scale noise and clears mixed in.
  task automatic run_gait(int n_words);
    int  done;
    int  burst;
    int  amp;
    int  roll;
    bit  loud;
    done = 0;
    loud = 1'($urandom_range(0, 1));
    while (done < n_words) begin
      loud  = !loud;
      burst = $urandom_range(3, 14);
      amp   = loud ? $urandom_range(12000, 32767) : $urandom_range(0, 8000);
      for (int k = 0; k < burst && done < n_words; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 4)
          send_word(CMD_CLEAR, AXIS_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom));
        else if (roll < 12)
          send_word(CMD_SAMPLE, AXIS_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom));
        else
          send_word(CMD_SAMPLE, axis_within(amp), axis_within(amp), axis_within(amp));
        done++;
      end
      if (!calm && $urandom_range(0, 19) == 0) wait_drained();
    end
  endtask

  // New thresholds are only written once the block has gone quiet.
  task automatic run_setting(logic [THR_W-1:0] up, logic [THR_W-1:0] lo);
    wait_drained();
    write_reg(REG_UPPER, up);
    write_reg(REG_LOWER, lo);
    settings_done++;
    run_gait(WORDS_PER_SETTING);
  endtask

  initial begin
    logic [THR_W-1:0] lo;
    logic [THR_W-1:0] up;
    rst             = 1'b1;
    cfg_wen         = 1'b0;
    cfg_idx         = REG_UPPER;
    cfg_wdata       = '0;
    samples.valid   = 1'b0;
    samples.cmd     = CMD_SAMPLE;
    samples.accel_x = '0;
    samples.accel_y = '0;
    samples.accel_z = '0;
    results.ready   = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part with the reset thresholds. A clear on an empty detector,
    // then the fill with full-scale and zero axes; the completing word
    // decides nothing.
    send_word(CMD_CLEAR, 16'sh1234, AX_MIN, AX_MAX);
    send_word(CMD_SAMPLE, AX_MIN, AX_MIN, AX_MIN);
    send_word(CMD_SAMPLE, AX_MAX, AX_MAX, AX_MAX);
    send_word(CMD_SAMPLE, AX_MIN, AX_MAX, 16'sh0000);
    send_word(CMD_SAMPLE, 16'sh0000, 16'sh0000, 16'sh0000);
    send_word(CMD_SAMPLE, -16'sd1, 16'sd1, -16'sd1);
    repeat (5) send_word(CMD_SAMPLE, AX_MIN, AX_MIN, AX_MIN);
    // First decision rises into the high phase; a clear there keeps the phase.
    send_word(CMD_SAMPLE, AX_MIN, AX_MIN, AX_MIN);
    send_word(CMD_CLEAR, AX_MAX, AX_MAX, AX_MAX);
    // Silence drains the window below the lower threshold.
    repeat (10) send_word(CMD_SAMPLE, 16'sh0000, 16'sh0000, 16'sh0000);
    // One full-scale word alone stays just under the upper threshold; two rise.
    send_word(CMD_SAMPLE, AX_MIN, AX_MIN, AX_MIN);
    send_word(CMD_SAMPLE, AX_MIN, AX_MIN, AX_MIN);

    // Random part over several threshold settings, extremes first.
    run_setting(THR_MAX, '0);
    run_setting('0, '0);
    run_setting(THR_MAX, THR_MAX);
    run_setting(UPPER_RESET, LOWER_RESET);
    lo = THR_W'($urandom_range(500_000_000, 32'd3_500_000_000));
    run_setting(lo + THR_W'($urandom_range(0, 2_000_000_000)), lo);
    up = THR_W'($urandom_range(1_000_000_000, 32'd3_000_000_000));
    run_setting(up, up + THR_W'($urandom_range(100_000_000, 32'd3_000_000_000)));
    run_setting(THR_W'({$urandom, $urandom}) >> $urandom_range(0, 6),
                THR_W'({$urandom, $urandom}) >> $urandom_range(2, 8));

    wait_drained();
    repeat (12) @(negedge clk);
    $display("Covered %0d sample words (%0d clears) over %0d threshold settings,",
             words_sent, clears_sent, settings_done + 1);
    $display("with %0d step rises seen by the detector.", rises);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== step_counter_magnitude_hysteresis.f =====
rtl/scmh_pkg.sv
rtl/scmh_ifs.sv
rtl/scmh_square_lane.sv
rtl/scmh_merge.sv
rtl/scmh_window.sv
rtl/step_counter_magnitude_hysteresis.sv
rtl/scmh_checker.sv
bench/step_count_checker.sv
bench/step_counter_magnitude_hysteresis_test.sv
